// File: hw/rtl/kmp_pkg.sv
package kmp_pkg;

    localparam int MAX_PATTERN_DEF = 64;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_SEARCH = 2'd2
    } func_t;

    typedef struct packed {
        logic valid;
        logic found;
        logic truncated;
    } kmp_res_t;

endpackage

// File: hw/rtl/kmp_core.sv
module kmp_core #(
    parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        in_func,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    input  logic              out_free,
    output kmp_pkg::kmp_res_t res_o
);
    import kmp_pkg::*;

    localparam int IW = $clog2(MAX_PATTERN);
    localparam int LW = $clog2(MAX_PATTERN + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_PUSH = 3'b100
    } state_t;

    state_t         state_reg, state_next;
    logic [LW-1:0]  len_reg, len_next;
    logic [IW-1:0]  tracker_reg, tracker_next;
    logic [LW-1:0]  match_reg, match_next;
    logic           decided_reg, decided_next;
    logic           overflow_reg, overflow_next;
    logic           is_append_reg, is_append_next;
    logic [7:0]     byte_reg, byte_next;
    logic           last_reg, last_next;
    logic [IW-1:0]  k_reg, k_next;
    logic           found_reg, found_next;

    logic [7:0]     store_mem [MAX_PATTERN];
    logic [IW-1:0]  fail_mem [MAX_PATTERN];
    logic [7:0]     store_rd_reg;
    logic [IW-1:0]  fail_rd_reg;

    logic           store_we;
    logic [IW-1:0]  store_waddr;
    logic [7:0]     store_wdata;
    logic [IW-1:0]  store_raddr;
    logic           fail_we;
    logic [IW-1:0]  fail_waddr;
    logic [IW-1:0]  fail_wdata;
    logic [IW-1:0]  fail_raddr;

    logic           accept;
    logic           eq;
    logic [LW-1:0]  k_fin;
    logic           emit;
    logic           emit_found;
    logic [IW-1:0]  j0;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign eq       = (store_rd_reg == byte_reg);
    assign k_fin    = eq ? (LW'(k_reg) + LW'(1)) : '0;
    assign j0       = (match_reg >= len_reg) ? '0 : match_reg[IW-1:0];

    always_comb begin
        state_next     = state_reg;
        len_next       = len_reg;
        tracker_next   = tracker_reg;
        match_next     = match_reg;
        decided_next   = decided_reg;
        overflow_next  = overflow_reg;
        is_append_next = is_append_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        k_next         = k_reg;
        found_next     = found_reg;
        store_we       = 1'b0;
        store_waddr    = len_reg[IW-1:0];
        store_wdata    = in_byte;
        store_raddr    = '0;
        fail_we        = 1'b0;
        fail_waddr     = len_reg[IW-1:0];
        fail_wdata     = '0;
        fail_raddr     = '0;
        emit           = 1'b0;
        emit_found     = 1'b0;
        res_o          = '0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    byte_next = in_byte;
                    last_next = in_last;
                    case (in_func)
                        FUNC_CLEAR: begin
                            len_next      = '0;
                            tracker_next  = '0;
                            overflow_next = 1'b0;
                            match_next    = '0;
                            decided_next  = 1'b0;
                        end
                        FUNC_APPEND: begin
                            match_next   = '0;
                            decided_next = 1'b0;
                            if (len_reg == LW'(MAX_PATTERN)) begin
                                overflow_next = 1'b1;
                            end else if (len_reg == '0) begin
                                store_we     = 1'b1;
                                fail_we      = 1'b1;
                                tracker_next = '0;
                                len_next     = LW'(1);
                            end else begin
                                store_we       = 1'b1;
                                store_raddr    = tracker_reg;
                                fail_raddr     = (tracker_reg == '0) ? '0 : tracker_reg - 1'b1;
                                k_next         = tracker_reg;
                                is_append_next = 1'b1;
                                state_next     = ST_WALK;
                            end
                        end
                        FUNC_SEARCH: begin
                            if (!decided_reg) begin
                                if (len_reg == '0) begin
                                    emit         = 1'b1;
                                    emit_found   = 1'b1;
                                    decided_next = 1'b1;
                                    if (in_last) begin
                                        match_next   = '0;
                                        decided_next = 1'b0;
                                    end
                                end else begin
                                    store_raddr    = j0;
                                    fail_raddr     = (j0 == '0) ? '0 : j0 - 1'b1;
                                    k_next         = j0;
                                    is_append_next = 1'b0;
                                    state_next     = ST_WALK;
                                end
                            end else if (in_last) begin
                                match_next   = '0;
                                decided_next = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (eq || k_reg == '0) begin
                    state_next = ST_IDLE;
                    if (is_append_reg) begin
                        fail_we      = 1'b1;
                        fail_wdata   = k_fin[IW-1:0];
                        tracker_next = k_fin[IW-1:0];
                        len_next     = len_reg + 1'b1;
                    end else begin
                        match_next = k_fin;
                        if (k_fin == len_reg || last_reg) begin
                            emit         = 1'b1;
                            emit_found   = (k_fin == len_reg);
                            decided_next = 1'b1;
                        end
                        if (last_reg) begin
                            match_next   = '0;
                            decided_next = 1'b0;
                        end
                    end
                end else begin
                    k_next      = fail_rd_reg;
                    store_raddr = fail_rd_reg;
                    fail_raddr  = (fail_rd_reg == '0) ? '0 : fail_rd_reg - 1'b1;
                end
            end
            ST_PUSH: begin
                if (out_free) begin
                    res_o.valid     = 1'b1;
                    res_o.found     = found_reg;
                    res_o.truncated = overflow_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit) begin
            if (out_free) begin
                res_o.valid     = 1'b1;
                res_o.found     = emit_found;
                res_o.truncated = overflow_reg;
            end else begin
                found_next = emit_found;
                state_next = ST_PUSH;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            len_reg      <= '0;
            tracker_reg  <= '0;
            match_reg    <= '0;
            decided_reg  <= 1'b0;
            overflow_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            tracker_reg  <= tracker_next;
            match_reg    <= match_next;
            decided_reg  <= decided_next;
            overflow_reg <= overflow_next;
        end
    end

    always_ff @(posedge aclk) begin
        is_append_reg <= is_append_next;
        byte_reg      <= byte_next;
        last_reg      <= last_next;
        k_reg         <= k_next;
        found_reg     <= found_next;
    end

    // pattern bytes
    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_mem[store_waddr] <= store_wdata;
        end
        store_rd_reg <= store_mem[store_raddr];
    end

    // failure values
    always_ff @(posedge aclk) begin
        if (fail_we) begin
            fail_mem[fail_waddr] <= fail_wdata;
        end
        fail_rd_reg <= fail_mem[fail_raddr];
    end

    a_fail_within_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        fail_we |-> (fail_wdata <= fail_waddr))
        else $error("failure value beyond its position");

    a_tracker_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (len_reg != '0) |-> (LW'(tracker_reg) < len_reg))
        else $error("prefix tracker outside pattern");

    a_walk_in_pattern: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (LW'(k_reg) < len_reg))
        else $error("probe index outside written pattern");

    a_res_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        res_o.valid |-> out_free)
        else $error("result issued while output slot busy");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LW'(MAX_PATTERN))
        else $error("pattern length beyond store");

endmodule

// File: hw/rtl/kmp_stream_matcher_top.sv
// channel  | ports                                    | direction
// ---------+------------------------------------------+-----------
// input    | s_valid s_ready s_func s_data_byte        | in
//          | s_text_last                              |
// result   | m_valid m_ready m_found                  | out
//          | m_pattern_truncated                      |
//
// handled in the idle state: clear, unused codes, appends that are dropped or go to an empty
// pattern, and text bytes of a decided search or with an empty pattern
// other appends and text bytes go on to the walk state, which follows the failure-table fallbacks,
// fallbacks amortized to at most one per byte
// a result waits in the output register while the next transaction is taken,
// a second one stalls the input until the first is taken; aresetn is synchronous
module kmp_stream_matcher_top #(
    parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_func,
    input  logic [7:0] s_data_byte,
    input  logic       s_text_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_found,
    output logic       m_pattern_truncated
);
    import kmp_pkg::*;

    kmp_res_t res;
    logic     out_free;
    logic     m_valid_reg, m_valid_next;
    logic     m_found_reg;
    logic     m_trunc_reg;

    assign out_free = !m_valid_reg || m_ready;

    kmp_core #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_func  (s_func),
        .in_byte  (s_data_byte),
        .in_last  (s_text_last),
        .out_free (out_free),
        .res_o    (res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res.valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            m_found_reg <= res.found;
            m_trunc_reg <= res.truncated;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_found             = m_found_reg;
    assign m_pattern_truncated = m_trunc_reg;

endmodule

// File: tb/kmp_stream_matcher_top_tb.sv
`timescale 1ns / 1ps

module kmp_stream_matcher_top_tb;
    import kmp_pkg::*;

    localparam int MAX_PATTERN = MAX_PATTERN_DEF;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 600;
    localparam int PHASE_ITEMS = 70;
    localparam int HOLDOFF_AT = 10;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic found;
        logic truncated;
    } verdict_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data;
        logic       last;
        logic       typed;
        logic       typed_res;
        logic       found;
        logic       truncated;
    } script_row_t;

    localparam int SCRIPT_LEN = 23;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{FUNC_SEARCH, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0},   // empty pattern hits at once
        '{FUNC_SEARCH, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
        '{FUNC_UNUSED, 8'hA5, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
        '{FUNC_APPEND, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{FUNC_APPEND, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
        '{FUNC_APPEND, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{FUNC_SEARCH, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{FUNC_SEARCH, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{FUNC_SEARCH, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},   // mismatch, fall back
        '{FUNC_SEARCH, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{FUNC_SEARCH, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{FUNC_SEARCH, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{FUNC_SEARCH, 8'h55, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},   // silent after match
        '{FUNC_SEARCH, 8'h11, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
        '{FUNC_SEARCH, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{FUNC_UNUSED, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{FUNC_APPEND, 8'h80, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},   // abandons the search
        '{FUNC_SEARCH, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{FUNC_SEARCH, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{FUNC_SEARCH, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{FUNC_SEARCH, 8'h80, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},   // match on the last byte
        '{FUNC_CLEAR,  8'hAA, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
        '{FUNC_SEARCH, 8'h7F, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0}
    };

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_func = FUNC_CLEAR;
    logic [7:0] s_data_byte = 8'h00;
    logic       s_text_last = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_found;
    logic       m_pattern_truncated;

    logic [7:0] pat_mem [MAX_PATTERN];
    logic [5:0] fail_mem [MAX_PATTERN];
    int         pat_len = 0;
    int         border_len = 0;
    int         matched = 0;
    bit         decided = 1'b0;
    bit         overflow = 1'b0;

    verdict_t   search_verdicts [$];
    int         fail_count = 0;
    int         accepted_items = 0;
    int         random_items = 0;
    int         results_seen = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         hold_left = 0;
    bit         held = 1'b0;

    always #1 aclk = ~aclk;

    kmp_stream_matcher_top u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_func              (s_func),
        .s_data_byte         (s_data_byte),
        .s_text_last         (s_text_last),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_found             (m_found),
        .m_pattern_truncated (m_pattern_truncated)
    );

    function automatic bit kmp_predict(input logic [1:0] func, input logic [7:0] data,
                                       input logic last, output verdict_t v);
        int k;
        bit hit;
        kmp_predict = 1'b0;
        v = '0;
        hit = 1'b0;
        case (func)
            FUNC_CLEAR: begin
                pat_len = 0;
                border_len = 0;
                overflow = 1'b0;
                matched = 0;
                decided = 1'b0;
            end
            FUNC_APPEND: begin
                if (pat_len >= MAX_PATTERN) begin
                    overflow = 1'b1;
                end else begin
                    k = border_len;
                    pat_mem[pat_len] = data;
                    if (pat_len == 0) begin
                        k = 0;
                    end else begin
                        while (k > 0 && k < pat_len && pat_mem[k] != data)
                            k = int'(fail_mem[k - 1]);
                        if (k < pat_len && pat_mem[k] == data)
                            k++;
                    end
                    fail_mem[pat_len] = 6'(k);
                    border_len = k;
                    pat_len++;
                end
                matched = 0;
                decided = 1'b0;
            end
            FUNC_SEARCH: begin
                if (!decided) begin
                    if (pat_len == 0) begin
                        hit = 1'b1;
                    end else begin
                        k = (matched >= pat_len) ? 0 : matched;
                        while (k > 0 && pat_mem[k] != data)
                            k = int'(fail_mem[k - 1]);
                        if (pat_mem[k] == data)
                            k++;
                        matched = k;
                        hit = (k == pat_len);
                    end
                    if (hit || last) begin
                        v.found = hit;
                        v.truncated = overflow;
                        decided = 1'b1;
                        kmp_predict = 1'b1;
                    end
                end
                if (last) begin
                    matched = 0;
                    decided = 1'b0;
                end
            end
            default: ;
        endcase
    endfunction

    task automatic put_item(input logic [1:0] func, input logic [7:0] data, input logic last,
                            output bit has_res, output verdict_t v);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= func;
        s_data_byte <= data;
        s_text_last <= last;
        do @(posedge aclk); while (!s_ready);
        has_res = kmp_predict(func, data, last, v);
        accepted_items++;
        case ((accepted_items / PHASE_ITEMS) % 4)
            0: begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            1: begin
                send_idle_pct = 55;
                recv_stall_pct = 0;
            end
            2: begin
                send_idle_pct = 0;
                recv_stall_pct = 55;
            end
            default: begin
                send_idle_pct = 25;
                recv_stall_pct = 25;
            end
        endcase
    endtask

    task automatic feed(input logic [1:0] func, input logic [7:0] data, input logic last);
        bit has_res;
        verdict_t v;
        put_item(func, data, last, has_res, v);
        if (has_res)
            search_verdicts.push_back(v);
        if (func != FUNC_UNUSED)
            random_items++;
    endtask

    task automatic run_sequence(input bit long_pattern);
        logic [7:0] alpha [3];
        logic [7:0] pat_q [$];
        logic [7:0] text_q [$];
        int n_alpha;
        int pat_n;
        int text_n;
        int insert_at;
        int embed_n;
        foreach (alpha[i])
            alpha[i] = 8'($urandom_range(0, 255));
        n_alpha = $urandom_range(1, 3);
        if ($urandom_range(0, 4) != 0)
            feed(FUNC_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        if (long_pattern)
            pat_n = $urandom_range(MAX_PATTERN - 4, MAX_PATTERN + 6);
        else
            pat_n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
        for (int i = 0; i < pat_n; i++) begin
            pat_q.push_back(alpha[$urandom_range(0, n_alpha - 1)]);
            feed(FUNC_APPEND, pat_q[i], 1'($urandom_range(0, 1)));
        end
        repeat ($urandom_range(1, 4)) begin
            text_q.delete();
            text_n = long_pattern ? $urandom_range(0, 16) : $urandom_range(0, 10);
            for (int i = 0; i < text_n; i++)
                text_q.push_back(alpha[$urandom_range(0, n_alpha - 1)]);
            if ($urandom_range(0, 1) == 1) begin
                insert_at = $urandom_range(0, text_q.size());
                embed_n = (pat_q.size() > MAX_PATTERN) ? MAX_PATTERN : pat_q.size();
                for (int i = embed_n - 1; i >= 0; i--)
                    text_q.insert(insert_at, pat_q[i]);
            end
            if (text_q.size() == 0)
                text_q.push_back(alpha[0]);
            foreach (text_q[i]) begin
                case ($urandom_range(0, 49))
                    0: feed(FUNC_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    1: feed(FUNC_SEARCH, 8'($urandom_range(0, 255)), 1'b0);
                    2: feed(FUNC_APPEND, alpha[$urandom_range(0, n_alpha - 1)], 1'b0);
                    default: ;
                endcase
                feed(FUNC_SEARCH, text_q[i], i == text_q.size() - 1);
            end
        end
    endtask

    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (search_verdicts.size() == 0) begin
                $display("%0t: unexpected result found=%0b truncated=%0b",
                         $time, m_found, m_pattern_truncated);
                fail_count++;
            end else begin
                want = search_verdicts.pop_front();
                if (m_found !== want.found) begin
                    $display("%0t: found mismatch expected %0b actual %0b",
                             $time, want.found, m_found);
                    fail_count++;
                end
                if (m_pattern_truncated !== want.truncated) begin
                    $display("%0t: pattern_truncated mismatch expected %0b actual %0b",
                             $time, want.truncated, m_pattern_truncated);
                    fail_count++;
                end
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!held && results_seen == HOLDOFF_AT) begin
            // long receiver hold-off so the block backs up into its input
            held = 1'b1;
            hold_left = HOLDOFF_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial begin
        bit has_res;
        verdict_t v;
        int seq_no;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < SCRIPT_LEN; i++) begin
            put_item(SCRIPT[i].func, SCRIPT[i].data, SCRIPT[i].last, has_res, v);
            if (SCRIPT[i].typed) begin
                if (SCRIPT[i].typed_res)
                    search_verdicts.push_back('{SCRIPT[i].found, SCRIPT[i].truncated});
            end else if (has_res) begin
                search_verdicts.push_back(v);
            end
        end
        seq_no = 0;
        while (random_items < RANDOM_ITEMS) begin
            run_sequence(seq_no == 1 || $urandom_range(0, 11) == 0);
            seq_no++;
        end
        s_valid <= 1'b0;
        while (search_verdicts.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("PASS kmp_stream_matcher_top");
        else
            $display("FAIL kmp_stream_matcher_top");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("%0t: timeout, %0d transactions still expected", $time, search_verdicts.size());
        $display("FAIL kmp_stream_matcher_top");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/kmp_pkg.sv
hw/rtl/kmp_core.sv
hw/rtl/kmp_stream_matcher_top.sv
tb/kmp_stream_matcher_top_tb.sv
